/* sv/ascp_pkg.sv */
// shared types and constants of the ansi sgr color parser
// no dependencies; imported by every module of the block
package ascp_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned QUEUE_DEPTH = 4;  // power of two, pointers wrap freely
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QLEVEL_W    = QPTR_W + 1;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [23:0] DEFAULT_COLOR_RST = 24'h7AF53D;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [23:0] fore_color;
    logic        is_bold;
    logic        last_result;
  } result_t;

  // all results caused by one input item, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]             count;
    result_t [MAX_RESULTS-1:0]    res;
  } bundle_t;

  // parser status seen by the top-level checks
  typedef struct packed {
    logic mode_normal;
    logic line_has_chars;
    logic line_emitted;
  } front_status_t;

endpackage

/* sv/ascp_front.sv */
// front end: escape-sequence parser, color state and result bundling
// depends on ascp_pkg; feeds the bundle queue
module ascp_front
  import ascp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  in_item_t      byte_item,
  input  logic          cfg_valid,
  input  logic [23:0]   cfg_data,
  input  logic          queue_full,
  output logic          push,
  output bundle_t       push_bundle,
  output front_status_t status
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_PARAM  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [23:0] color;
    logic        bold;
  } sgr_t;

  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [7:0] SGR_RESET        = 8'd0;
  localparam logic [7:0] SGR_BOLD         = 8'd1;
  localparam logic [7:0] SGR_NOT_BOLD     = 8'd22;
  localparam logic [7:0] SGR_DEFAULT_FG   = 8'd39;
  localparam logic [7:0] SGR_FG_FIRST     = 8'd30;
  localparam logic [7:0] SGR_FG_LAST      = 8'd37;
  localparam logic [7:0] SGR_BRIGHT_FIRST = 8'd90;
  localparam logic [7:0] SGR_BRIGHT_LAST  = 8'd97;

  localparam logic [23:0] PALETTE [8] = '{
    24'h7A706A, 24'h5555FF, 24'h7BFA50, 24'h8CFAF1,
    24'hFFB66C, 24'hC679FF, 24'hFDE98B, 24'hF2F8F8
  };

  function automatic sgr_t apply_code(input logic [7:0] code, input sgr_t cur,
                                      input logic [23:0] dflt);
    sgr_t       r;
    logic [7:0] off;
    r   = cur;
    off = 8'd0;
    case (code) inside
      SGR_RESET: begin
        r.color = dflt;
        r.bold  = 1'b0;
      end
      SGR_BOLD:       r.bold  = 1'b1;
      SGR_NOT_BOLD:   r.bold  = 1'b0;
      SGR_DEFAULT_FG: r.color = dflt;
      [SGR_FG_FIRST:SGR_FG_LAST]: begin
        off     = code - SGR_FG_FIRST;
        r.color = PALETTE[off[2:0]];
      end
      [SGR_BRIGHT_FIRST:SGR_BRIGHT_LAST]: begin
        off     = code - SGR_BRIGHT_FIRST;
        r.color = PALETTE[off[2:0]];
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  function automatic result_t mk_char(input logic [7:0] ch, input logic [23:0] color,
                                      input logic bold);
    result_t r;
    r.kind        = KIND_CHAR;
    r.char_code   = ch;
    r.fore_color  = color;
    r.is_bold     = bold;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_eol();
    result_t r;
    r             = '0;
    r.kind        = KIND_EOL;
    return r;
  endfunction

  mode_t       mode, mode_next;
  logic [23:0] default_color;
  logic [23:0] active_color, active_color_next;
  logic        active_bold, active_bold_next;
  logic [23:0] tent_color, tent_color_next;
  logic        tent_bold, tent_bold_next;
  logic [7:0]  code_accum, code_accum_next;
  logic        line_has_chars, line_has_chars_next;
  logic        line_emitted, line_emitted_next;

  result_t [MAX_RESULTS-1:0] slots;
  logic [CNT_W-1:0]          cnt;
  logic                      do_normal;
  logic [11:0]               acc_x10;
  sgr_t                      sgr_new;
  logic [7:0]                b;
  logic                      eot;
  logic                      accept;

  assign b          = byte_item.text_byte;
  assign eot        = byte_item.end_of_text;
  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    mode_next           = mode;
    active_color_next   = active_color;
    active_bold_next    = active_bold;
    tent_color_next     = tent_color;
    tent_bold_next      = tent_bold;
    code_accum_next     = code_accum;
    line_has_chars_next = line_has_chars;
    line_emitted_next   = line_emitted;
    slots               = '0;
    cnt                 = '0;
    do_normal           = 1'b0;
    acc_x10             = {1'b0, code_accum, 3'b000} + {3'b000, code_accum, 1'b0}
                          + {8'd0, b[3:0]};
    sgr_new             = apply_code(code_accum, '{color: tent_color, bold: tent_bold},
                                     default_color);

    case (mode)
      MODE_ESC: begin
        if (b == CH_LBRACK) begin
          mode_next       = MODE_PARAM;
          tent_color_next = active_color;
          tent_bold_next  = active_bold;
          code_accum_next = 8'd0;
        end else begin
          // escape not followed by a bracket prints as a character
          mode_next           = MODE_NORMAL;
          slots[cnt]          = mk_char(CH_ESC, active_color, active_bold);
          cnt                 = cnt + 1'b1;
          line_has_chars_next = 1'b1;
          do_normal           = 1'b1;
        end
      end
      MODE_PARAM: begin
        case (b) inside
          [CH_ZERO:CH_NINE]: code_accum_next = (acc_x10 > 12'd255) ? 8'hFF : acc_x10[7:0];
          CH_SEMI: begin
            tent_color_next = sgr_new.color;
            tent_bold_next  = sgr_new.bold;
            code_accum_next = 8'd0;
          end
          CH_M: begin
            active_color_next = sgr_new.color;
            active_bold_next  = sgr_new.bold;
            tent_color_next   = sgr_new.color;
            tent_bold_next    = sgr_new.bold;
            code_accum_next   = 8'd0;
            mode_next         = MODE_NORMAL;
          end
          default: begin
            // bad terminator: abort and swallow
            code_accum_next = 8'd0;
            mode_next       = MODE_NORMAL;
          end
        endcase
      end
      default: begin
        mode_next = MODE_NORMAL;
        do_normal = 1'b1;
      end
    endcase

    if (do_normal) begin
      if (b == CH_ESC) begin
        if (eot) begin
          slots[cnt]          = mk_char(b, active_color, active_bold);
          cnt                 = cnt + 1'b1;
          line_has_chars_next = 1'b1;
        end else begin
          mode_next = MODE_ESC;
        end
      end else if (b == CH_CR) begin
        // dropped
      end else if (b == CH_LF) begin
        slots[cnt]          = mk_eol();
        cnt                 = cnt + 1'b1;
        line_has_chars_next = 1'b0;
        line_emitted_next   = 1'b1;
      end else begin
        slots[cnt]          = mk_char(b, active_color, active_bold);
        cnt                 = cnt + 1'b1;
        line_has_chars_next = 1'b1;
      end
    end

    if (eot) begin
      if (line_has_chars_next || !line_emitted_next) begin
        slots[cnt] = mk_eol();
        cnt        = cnt + 1'b1;
      end
      mode_next           = MODE_NORMAL;
      active_color_next   = default_color;
      active_bold_next    = 1'b0;
      tent_color_next     = default_color;
      tent_bold_next      = 1'b0;
      code_accum_next     = 8'd0;
      line_has_chars_next = 1'b0;
      line_emitted_next   = 1'b0;
    end

    if (cnt != '0) begin
      slots[cnt - 1'b1].last_result = 1'b1;
    end
  end

  assign push              = accept && (cnt != '0);
  assign push_bundle.count = cnt;
  assign push_bundle.res   = slots;

  assign status.mode_normal    = (mode == MODE_NORMAL);
  assign status.line_has_chars = line_has_chars;
  assign status.line_emitted   = line_emitted;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      default_color  <= DEFAULT_COLOR_RST;
      active_color   <= DEFAULT_COLOR_RST;
      active_bold    <= 1'b0;
      tent_color     <= DEFAULT_COLOR_RST;
      tent_bold      <= 1'b0;
      code_accum     <= 8'd0;
      line_has_chars <= 1'b0;
      line_emitted   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        default_color <= cfg_data;
      end
      if (accept) begin
        mode           <= mode_next;
        active_color   <= active_color_next;
        active_bold    <= active_bold_next;
        tent_color     <= tent_color_next;
        tent_bold      <= tent_bold_next;
        code_accum     <= code_accum_next;
        line_has_chars <= line_has_chars_next;
        line_emitted   <= line_emitted_next;
      end
    end
  end

endmodule

/* sv/ascp_queue.sv */
// bundle queue between parser front end and output back end
// depends on ascp_pkg
module ascp_queue
  import ascp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_bundle,
  input  logic    pop,
  output bundle_t head,
  output logic    empty,
  output logic    full
);

  bundle_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QLEVEL_W-1:0]    level;

  assign head  = entries[rd_ptr];
  assign empty = (level == '0);
  assign full  = (level == QLEVEL_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

/* sv/ascp_back.sv */
// back end: unpacks queued bundles into single result items
// depends on ascp_pkg; reads the head of ascp_queue
module ascp_back
  import ascp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    empty,
  output logic    pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res_item
);

  logic [CNT_W-1:0] idx;
  logic             load;
  logic             at_last;

  assign load    = !empty && (!res_valid || res_ready);
  assign at_last = (idx == head.count - 1'b1);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (load) begin
        res_valid <= 1'b1;
        res_item  <= head.res[idx];
        idx       <= at_last ? '0 : idx + 1'b1;
      end
    end
  end

endmodule

/* sv/ansi_sgr_color_parser.sv */
// top level of the ansi sgr color parser: front end, bundle queue, back end
// depends on ascp_pkg, ascp_front, ascp_queue and ascp_back
//
// The block takes one text byte per cycle. The front end parses ESC [ ... m
// color sequences and turns each byte into zero to three result items
// (characters with color and bold, or end of line), which it writes as one
// bundle into a four-entry queue. The back end drains the queue one result
// item per cycle, unless the output is stalled, through a registered output;
// bytes with no result push no bundle. The input stalls only while the queue
// is full, which takes a sustained run of multi-result bytes or a stalled
// output. The first result of a byte passes through the queue and the output
// register before it is presented. The color register is written through cfg
// at any time the block is idle and takes effect at the next reset or
// default-color code or the next end of text.
module ansi_sgr_color_parser
  import ascp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  in_item_t    byte_item,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic          push;
  bundle_t       push_bundle;
  bundle_t       head;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  front_status_t status;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // parser and color state
  ascp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .queue_full  (q_full),
    .push        (push),
    .push_bundle (push_bundle),
    .status      (status)
  );

  // decouples parsing from output backpressure
  ascp_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .head        (head),
    .empty       (q_empty),
    .full        (q_full)
  );

  // one result item per cycle out of the head bundle while the output is not stalled
  ascp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // end of text returns the parser to its defaults
  a_eot_defaults: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && byte_item.end_of_text |=>
      status.mode_normal && !status.line_has_chars && !status.line_emitted)
    else $error("parser state not back to defaults after end of text");

  // a pushed bundle is never empty and never lands in a full queue
  a_bundle_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> push_bundle.count != '0 && !q_full)
    else $error("empty bundle pushed or queue overrun");

  // the last slot of a pushed bundle carries the last-result mark
  a_bundle_last: assert property (@(posedge clk) disable iff (rst)
    push |-> push_bundle.res[push_bundle.count - 1'b1].last_result)
    else $error("bundle without last-result mark on its final slot");

  // an end of line carries no character, color or bold
  a_eol_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == KIND_EOL |->
      res_item.char_code == '0 && res_item.fore_color == '0 && !res_item.is_bold)
    else $error("end of line with nonzero payload");

endmodule

/* tb/tb.sv */
// self-checking testbench for the ansi sgr color parser
// holds a scoreboard class with its own parser model; depends on ascp_pkg and the RTL top
module tb;
  import ascp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // control bytes of the text stream
  localparam logic [7:0] BYTE_ESC      = 8'd27;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_LBRACKET = "[";
  localparam logic [7:0] BYTE_SEMI     = ";";
  localparam logic [7:0] BYTE_M        = "m";
  localparam logic [7:0] BYTE_DIGIT0   = "0";
  localparam logic [7:0] BYTE_DIGIT9   = "9";

  // sgr codes the parser reacts to
  localparam logic [7:0] SGR_RESET        = 8'd0;
  localparam logic [7:0] SGR_BOLD         = 8'd1;
  localparam logic [7:0] SGR_NORMAL       = 8'd22;
  localparam logic [7:0] SGR_DEFAULT_FG   = 8'd39;
  localparam logic [7:0] SGR_FG_FIRST     = 8'd30;
  localparam logic [7:0] SGR_FG_LAST      = 8'd37;
  localparam logic [7:0] SGR_BRIGHT_FIRST = 8'd90;
  localparam logic [7:0] SGR_BRIGHT_LAST  = 8'd97;

  // fixed palette, 0xBBGGRR, index 0 is the gray of code 30
  localparam logic [7:0][23:0] PALETTE = {
    24'hF2F8F8, 24'hFDE98B, 24'hC679FF, 24'hFFB66C,
    24'h8CFAF1, 24'h7BFA50, 24'h5555FF, 24'h7A706A
  };

  localparam int RESET_CYCLES   = 7;
  localparam int HOLD_OFF       = 8;     // settle margin for the output register and the four-entry queue
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int PHASE_BYTES    = 70;

  typedef enum logic [1:0] {MODE_TEXT, MODE_ESC, MODE_PARAMS} parse_mode_e;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_e;

  // parser model plus the queue of results still owed by the block
  class sgr_scoreboard;
    logic [23:0] default_color;
    parse_mode_e mode;
    logic [23:0] active_color;
    logic [23:0] tentative_color;
    logic        active_bold;
    logic        tentative_bold;
    logic [7:0]  code_accum;
    logic        line_has_chars;
    logic        line_emitted;
    result_t     step_results[$];
    result_t     expected_q[$];
    int          fail_count;
    int          results_checked;
    int          bytes_taken;

    function new();
      default_color   = DEFAULT_COLOR_RST;
      fail_count      = 0;
      results_checked = 0;
      bytes_taken     = 0;
      restore_defaults();
    endfunction

    function void restore_defaults();
      mode            = MODE_TEXT;
      active_color    = default_color;
      active_bold     = 1'b0;
      tentative_color = default_color;
      tentative_bold  = 1'b0;
      code_accum      = 8'd0;
      line_has_chars  = 1'b0;
      line_emitted    = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_result(logic kind, logic [7:0] ch, logic [23:0] col, logic bold);
      result_t r;
      r.kind        = kind;
      r.char_code   = ch;
      r.fore_color  = col;
      r.is_bold     = bold;
      r.last_result = 1'b0;
      step_results.insert(step_results.size(), r);
    endfunction

    function void put_char(logic [7:0] ch);
      push_result(KIND_CHAR, ch, active_color, active_bold);
      line_has_chars = 1'b1;
    endfunction

    function void put_eol();
      push_result(KIND_EOL, 8'h00, 24'h000000, 1'b0);
      line_has_chars = 1'b0;
      line_emitted   = 1'b1;
    endfunction

    // codes only touch the tentative copies, m commits them
    function void stage_code(logic [7:0] code);
      logic [7:0] idx;
      if (code == SGR_RESET) begin
        tentative_color = default_color;
        tentative_bold  = 1'b0;
      end else if (code == SGR_BOLD) begin
        tentative_bold = 1'b1;
      end else if (code == SGR_NORMAL) begin
        tentative_bold = 1'b0;
      end else if (code == SGR_DEFAULT_FG) begin
        tentative_color = default_color;
      end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
        idx = code - SGR_FG_FIRST;
        tentative_color = PALETTE[idx[2:0]];
      end else if (code >= SGR_BRIGHT_FIRST && code <= SGR_BRIGHT_LAST) begin
        idx = code - SGR_BRIGHT_FIRST;
        tentative_color = PALETTE[idx[2:0]];
      end
    endfunction

    function void plain_byte(logic [7:0] b, logic eot);
      if (b == BYTE_ESC) begin
        // an escape on the last byte of a text has nothing to introduce
        if (eot) put_char(b);
        else mode = MODE_ESC;
      end else if (b == BYTE_CR) begin
        // carriage return is dropped
      end else if (b == BYTE_LF) begin
        put_eol();
      end else begin
        put_char(b);
      end
    endfunction

    function void note_byte(in_item_t it);
      int unsigned acc;
      result_t     r;
      step_results.delete();
      bytes_taken++;
      case (mode)
        MODE_ESC: begin
          if (it.text_byte == BYTE_LBRACKET) begin
            mode            = MODE_PARAMS;
            tentative_color = active_color;
            tentative_bold  = active_bold;
            code_accum      = 8'd0;
          end else begin
            mode = MODE_TEXT;
            put_char(BYTE_ESC);
            plain_byte(it.text_byte, it.end_of_text);
          end
        end
        MODE_PARAMS: begin
          if (it.text_byte >= BYTE_DIGIT0 && it.text_byte <= BYTE_DIGIT9) begin
            acc        = int'(code_accum) * 10 + int'(it.text_byte - BYTE_DIGIT0);
            code_accum = (acc > 255) ? 8'd255 : 8'(acc);
          end else if (it.text_byte == BYTE_SEMI) begin
            stage_code(code_accum);
            code_accum = 8'd0;
          end else if (it.text_byte == BYTE_M) begin
            stage_code(code_accum);
            code_accum   = 8'd0;
            active_color = tentative_color;
            active_bold  = tentative_bold;
            mode         = MODE_TEXT;
          end else begin
            // bad terminator: sequence dropped, byte swallowed
            code_accum = 8'd0;
            mode       = MODE_TEXT;
          end
        end
        default: begin
          mode = MODE_TEXT;
          plain_byte(it.text_byte, it.end_of_text);
        end
      endcase
      if (it.end_of_text) begin
        if (line_has_chars || !line_emitted) put_eol();
        restore_defaults();
      end
      if (step_results.size() > 0) begin
        r = step_results[step_results.size() - 1];
        r.last_result = 1'b1;
        step_results[step_results.size() - 1] = r;
      end
      foreach (step_results[i]) expected_q.insert(expected_q.size(), step_results[i]);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected (kind %0d char %02h)",
                         got.kind, got.char_code));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      results_checked++;
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.char_code !== want.char_code)
        report($sformatf("char_code got %02h want %02h", got.char_code, want.char_code));
      if (got.fore_color !== want.fore_color)
        report($sformatf("fore_color got %06h want %06h", got.fore_color, want.fore_color));
      if (got.is_bold !== want.is_bold)
        report($sformatf("is_bold got %0d want %0d", got.is_bold, want.is_bold));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result got %0d want %0d", got.last_result, want.last_result));
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  in_item_t    byte_item = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  result_t     res_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = 24'h000000;

  sgr_scoreboard sb;
  stall_e        stall_mode = STALL_NONE;
  int            stall_tick = 0;
  int            gap_max = 0;
  int            burst_left = 0;
  int            sent_bytes = 0;
  int            idle_cycles = 0;
  logic [7:0]    text_bytes[$];

  ansi_sgr_color_parser DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: every handshake is seen here at the rising edge, inputs before results
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) sb.default_color = cfg_data;
      if (byte_valid && byte_ready) sb.note_byte(byte_item);
      if (res_valid && res_ready) sb.check_result(res_item);
      if ((cfg_valid && cfg_ready) || (byte_valid && byte_ready) || (res_valid && res_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // result side back-pressure, one pattern per phase
  always @(negedge clk) begin
    stall_tick = stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  res_ready <= 1'b1;
      STALL_LIGHT: res_ready <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY: res_ready <= ($urandom_range(0, 9) < 3);
      default:     res_ready <= ((stall_tick % 11) > 3);  // periodic stall pattern
    endcase
  end

  // watchdog: a long stretch with no handshake means the block hung
  initial begin
    wait (rst == 1'b0);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, sb.pending());
    $display("status: fail");
    $finish;
  end

  task write_color(logic [23:0] color);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task idle_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
  endtask

  // one item; the sender runs in bursts split by random gaps when gap_max is set
  task send_item(logic [7:0] b, logic eot);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, gap_max));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_item  <= '{text_byte: b, end_of_text: eot};
    do @(posedge clk); while (!byte_ready);
    sent_bytes++;
  endtask

  // the last byte of the buffered text carries the end-of-text flag
  task send_text();
    foreach (text_bytes[i]) send_item(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
  endtask

  // pause the sender until the block owes nothing, then let trailing no-result bytes settle
  task drain_all();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  function void add_byte(logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endfunction

  function void queue_string(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function void add_decimal(int unsigned v);
    if ($urandom_range(0, 7) == 0) add_byte(BYTE_DIGIT0);  // leading zero
    queue_string($sformatf("%0d", v));
  endfunction

  // mostly codes that do something, some that are ignored or saturate
  function int unsigned pick_code();
    case ($urandom_range(0, 11))
      0:       return SGR_RESET;
      1:       return SGR_BOLD;
      2:       return SGR_NORMAL;
      3:       return SGR_DEFAULT_FG;
      4, 5, 6: return SGR_FG_FIRST + $urandom_range(0, 7);
      7, 8, 9: return SGR_BRIGHT_FIRST + $urandom_range(0, 7);
      10:      return $urandom_range(0, 99);
      default: return $urandom_range(100, 9999);
    endcase
  endfunction

  function void add_params();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_byte(BYTE_SEMI);
      if ($urandom_range(0, 5) != 0) add_decimal(pick_code());  // otherwise empty param
    end
  endfunction

  function logic is_param_byte(logic [7:0] b);
    return (b >= BYTE_DIGIT0 && b <= BYTE_DIGIT9) || b == BYTE_SEMI || b == BYTE_M;
  endfunction

  // one random text: mostly plain runs, line ends and well-formed sgr sequences,
  // with some aborted sequences, stray escapes and odd endings mixed in
  function void build_text();
    int         segs;
    int         pick;
    logic [7:0] t;
    segs = $urandom_range(1, 7);
    for (int s = 0; s < segs; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 6) != 0) add_byte(8'($urandom_range(8'h20, 8'h7E)));
          else add_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick < 50) begin
        if ($urandom_range(0, 1)) add_byte(BYTE_CR);
        add_byte(BYTE_LF);
      end else if (pick < 85) begin
        add_byte(BYTE_ESC);
        add_byte(BYTE_LBRACKET);
        add_params();
        add_byte(BYTE_M);
      end else if (pick < 93) begin
        add_byte(BYTE_ESC);
        add_byte(BYTE_LBRACKET);
        add_params();
        case ($urandom_range(0, 2))
          0: t = BYTE_LF;
          1: t = BYTE_ESC;
          default: do t = 8'($urandom_range(0, 255)); while (is_param_byte(t));
        endcase
        add_byte(t);
      end else begin
        // escape not followed by a bracket comes out as a character
        add_byte(BYTE_ESC);
        do t = 8'($urandom_range(0, 255)); while (t == BYTE_LBRACKET);
        add_byte(t);
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        // text stops inside a sequence
        add_byte(BYTE_ESC);
        add_byte(BYTE_LBRACKET);
        add_params();
      end
      1: add_byte(BYTE_ESC);
      2: add_byte(BYTE_LF);
      default: ;
    endcase
  endfunction

  task random_texts(int nbytes);
    int start;
    start = sent_bytes;
    while (sent_bytes - start < nbytes) begin
      build_text();
      send_text();
      if ($urandom_range(0, 24) == 0) drain_all();
    end
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // phase one: black default, directed texts with no idling, then bursty random texts
    write_color(24'h000000);
    // single zero byte that is also the whole text
    add_byte(8'h00);
    send_text();
    // bold bright magenta applied only at m, a saturated code aborted by a swallowed lf,
    // an escape without bracket, an empty reset sequence, cr dropped, text ends on lf
    queue_string("\033[1;95mX");
    queue_string("\033[300\nY");
    queue_string("\033Z\033[m\015\n");
    send_text();
    // top byte value then an escape as the final byte
    add_byte(8'hFF);
    add_byte(BYTE_ESC);
    send_text();
    // text that ends inside a sequence
    queue_string("\033[3");
    send_text();
    gap_max = 8;
    random_texts(PHASE_BYTES);

    // phase two: white default, light random stalls
    drain_all();
    write_color(24'hFFFFFF);
    stall_mode = STALL_LIGHT;
    gap_max    = 12;
    random_texts(PHASE_BYTES);

    // phase three: random default, heavy stalls so the queue fills and input backs up
    drain_all();
    write_color(24'($urandom_range(0, 24'hFFFFFF)));
    stall_mode = STALL_HEAVY;
    gap_max    = 4;
    random_texts(PHASE_BYTES);

    // phase four: back to the reset color, periodic stalls, sender never idles
    drain_all();
    write_color(DEFAULT_COLOR_RST);
    stall_mode = STALL_PERIODIC;
    gap_max    = 0;
    random_texts(PHASE_BYTES);

    drain_all();
    $display("checked %0d results from %0d text bytes under four default colors",
             sb.results_checked, sb.bytes_taken);
    $display("covered sgr codes, aborted and unfinished escapes, bursts and output stalls");
    if (sb.fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
